### rtl/dma_pkg.sv
// Shared types and constants for the masked ALU.
`default_nettype none

package dma_pkg;

    localparam int WORD_W = 32;  // width of every share and fresh word on the ports
    localparam int KIND_W = 4;   // operation code width
    localparam int AMT_W  = 8;   // raw shift amount width
    localparam int NSH    = 3;   // share slots carried through the datapath

    // Operation codes; the codes above KIND_MULT give an all-zero result
    typedef enum logic [KIND_W-1:0] {
        KIND_AND  = 4'd0,
        KIND_OR   = 4'd1,
        KIND_XOR  = 4'd2,
        KIND_NOT  = 4'd3,
        KIND_SHR  = 4'd4,
        KIND_SHL  = 4'd5,
        KIND_ROTR = 4'd6,
        KIND_ROTL = 4'd7,
        KIND_ADD  = 4'd8,
        KIND_MULT = 4'd9
    } t_kind;

endpackage

`default_nettype wire

### rtl/dma_shift.sv
// Shift and rotate unit for a single share.
`default_nettype none

module dma_shift #(
    parameter int WIDTH = 32,
    parameter int CW    = $clog2(WIDTH)
) (
    input  var dma_pkg::t_kind    i_kind,
    input  wire logic [CW-1:0]    i_count,
    input  wire logic [WIDTH-1:0] i_value,
    output logic      [WIDTH-1:0] o_value
);

    logic [2*WIDTH-1:0] dbl;
    logic [2*WIDTH-1:0] dbl_r;
    logic [2*WIDTH-1:0] dbl_l;

    // Rotate through a doubled copy of the share
    assign dbl   = {i_value, i_value};
    assign dbl_r = dbl >> i_count;
    assign dbl_l = dbl << i_count;

    // Pick the operation; other kinds pass the share through
    always_comb begin
        case (i_kind)
            dma_pkg::KIND_SHR:  o_value = i_value >> i_count;
            dma_pkg::KIND_SHL:  o_value = i_value << i_count;
            dma_pkg::KIND_ROTR: o_value = dbl_r[WIDTH-1:0];
            dma_pkg::KIND_ROTL: o_value = dbl_l[2*WIDTH-1:WIDTH];
            default:            o_value = i_value;
        endcase
    end

endmodule

`default_nettype wire

### rtl/dom_masked_alu.sv
// Top level of the three-share masked ALU (DOM style AND and MULT gadgets).
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | into ALU  | i_in_valid / o_in_stall | i_kind, i_a_share0..2, i_b_share0..2,
//           |           |                         | i_fresh0..2, i_shift_amount
//   out     | from ALU  | o_out_valid/i_out_stall | o_out_share0..2
//
// One word per cycle sustained while the output is not stalled; a word passes the input
// register (loaded at acceptance), reshared cross-term and result registers to o_out_valid.
// The cross terms are registered before the shares are recombined, as the gadget requires.
// Reset is synchronous and clears the three stage valid flags only.
// A stalled output holds its word; upstream stages keep filling bubbles and the
// input stalls only once every stage is full.
`default_nettype none

module dom_masked_alu #(
    parameter int WIDTH  = 32,
    parameter int SHARES = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [dma_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_a_share0,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_a_share1,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_a_share2,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_b_share0,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_b_share1,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_b_share2,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_fresh0,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_fresh1,
    input  wire logic [dma_pkg::WORD_W-1:0]   i_fresh2,
    input  wire logic [dma_pkg::AMT_W-1:0]    i_shift_amount,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [dma_pkg::WORD_W-1:0]   o_out_share0,
    output logic      [dma_pkg::WORD_W-1:0]   o_out_share1,
    output logic      [dma_pkg::WORD_W-1:0]   o_out_share2
);

    localparam int  WORD_W = dma_pkg::WORD_W;
    localparam int  AMT_W  = dma_pkg::AMT_W;
    localparam int  NSH    = dma_pkg::NSH;
    localparam int  MW     = (WIDTH < WORD_W) ? WIDTH : WORD_W;  // significant operand bits
    localparam int  CW     = $clog2(WIDTH);
    localparam bit  THREE  = (SHARES == 3);

    // Stage flow control
    logic adv_in;
    logic adv_mid;
    logic adv_out;

    // Input stage
    logic               r_in_valid;
    dma_pkg::t_kind     r_in_kind;
    logic [CW-1:0]      r_in_count;
    logic [MW-1:0]      r_in_a [NSH];
    logic [MW-1:0]      r_in_b [NSH];
    logic [MW-1:0]      r_in_f [NSH];
    logic [CW-1:0]      n_in_count;
    logic [MW-1:0]      n_in_a [NSH];
    logic [MW-1:0]      n_in_b [NSH];
    logic [MW-1:0]      n_in_f [NSH];

    // Cross-term stage
    logic               r_mid_valid;
    logic               r_mid_arith;
    logic [WIDTH-1:0]   r_mid_t  [NSH][NSH];
    logic [WIDTH-1:0]   r_mid_rs [NSH];
    logic               n_mid_arith;
    logic [WIDTH-1:0]   n_mid_t  [NSH][NSH];
    logic [WIDTH-1:0]   n_mid_rs [NSH];

    // Result stage
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_share [NSH];
    logic [WORD_W-1:0]  n_out_share [NSH];

    // Working values of the cross-term stage
    logic [WIDTH-1:0]   xw   [NSH];
    logic [WIDTH-1:0]   yw   [NSH];
    logic [WIDTH-1:0]   fw   [NSH];
    logic [WIDTH-1:0]   rp   [NSH][NSH];
    logic [WIDTH-1:0]   shv  [NSH];
    logic [2*MW-1:0]    prod [NSH][NSH];

    // Advance a stage when the one after it can take its word
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_mid    = !r_mid_valid || adv_out;
    assign adv_in     = !r_in_valid  || adv_mid;
    assign o_in_stall = !adv_in;

    // Reduce the shift amount mod WIDTH by conditional subtraction, one bit a step
    always_comb begin
        logic [AMT_W-1:0] rem;
        logic [15:0]      step_v;
        rem = i_shift_amount;
        for (int k = AMT_W - 1; k >= 0; k--) begin
            step_v = 16'(WIDTH) << k;
            if (16'(rem) >= step_v) begin
                rem = rem - AMT_W'(step_v);
            end
        end
        n_in_count = CW'(rem);
    end

    // Cut the port words to the datapath; two-share builds drop share 2 and fresh1/fresh2
    always_comb begin
        n_in_a[0] = MW'(i_a_share0);
        n_in_a[1] = MW'(i_a_share1);
        n_in_a[2] = THREE ? MW'(i_a_share2) : '0;
        n_in_b[0] = MW'(i_b_share0);
        n_in_b[1] = MW'(i_b_share1);
        n_in_b[2] = THREE ? MW'(i_b_share2) : '0;
        n_in_f[0] = MW'(i_fresh0);
        n_in_f[1] = THREE ? MW'(i_fresh1) : '0;
        n_in_f[2] = THREE ? MW'(i_fresh2) : '0;
    end

    // Shift and rotate each share of A
    for (genvar g = 0; g < NSH; g++) begin : g_shift
        dma_shift #(
            .WIDTH (WIDTH),
            .CW    (CW)
        ) u_shift (
            .i_kind  (r_in_kind),
            .i_count (r_in_count),
            .i_value (WIDTH'(r_in_a[g])),
            .o_value (shv[g])
        );
    end

    // Widen operands, build the pairwise fresh words and all share products
    always_comb begin
        for (int i = 0; i < NSH; i++) begin
            xw[i] = WIDTH'(r_in_a[i]);
            yw[i] = WIDTH'(r_in_b[i]);
            fw[i] = WIDTH'(r_in_f[i]);
        end
        for (int i = 0; i < NSH; i++) begin
            rp[i][i] = '0;
            for (int j = 0; j < NSH; j++) begin
                prod[i][j] = {{MW{1'b0}}, r_in_a[i]} * {{MW{1'b0}}, r_in_b[j]};
            end
        end
        rp[0][1] = fw[0];
        rp[1][0] = fw[0];
        rp[0][2] = fw[1];
        rp[2][0] = fw[1];
        rp[1][2] = fw[2];
        rp[2][1] = fw[2];
    end

    // Form the reshared cross terms, or the finished share in the diagonal term
    always_comb begin
        n_mid_arith = 1'b0;
        for (int i = 0; i < NSH; i++) begin
            n_mid_rs[i] = '0;
            for (int j = 0; j < NSH; j++) begin
                n_mid_t[i][j] = '0;
            end
        end
        case (r_in_kind)
            dma_pkg::KIND_AND, dma_pkg::KIND_OR: begin
                for (int i = 0; i < NSH; i++) begin
                    for (int j = 0; j < NSH; j++) begin
                        n_mid_t[i][j] = (xw[i] & yw[j]) ^ rp[i][j];
                    end
                    if (r_in_kind == dma_pkg::KIND_OR) begin
                        n_mid_t[i][i] = n_mid_t[i][i] ^ xw[i] ^ yw[i];
                    end
                end
            end
            dma_pkg::KIND_XOR: begin
                for (int i = 0; i < NSH; i++) begin
                    n_mid_t[i][i] = xw[i] ^ yw[i];
                end
            end
            dma_pkg::KIND_NOT: begin
                for (int i = 0; i < NSH; i++) begin
                    n_mid_t[i][i] = xw[i];
                end
                n_mid_t[0][0] = ~xw[0];
            end
            dma_pkg::KIND_SHR, dma_pkg::KIND_SHL,
            dma_pkg::KIND_ROTR, dma_pkg::KIND_ROTL: begin
                for (int i = 0; i < NSH; i++) begin
                    n_mid_t[i][i] = shv[i];
                end
            end
            dma_pkg::KIND_ADD: begin
                for (int i = 0; i < NSH; i++) begin
                    n_mid_t[i][i] = xw[i] + yw[i];
                end
            end
            dma_pkg::KIND_MULT: begin
                // lower share of a pair adds its fresh word, upper share subtracts it
                n_mid_arith = 1'b1;
                for (int i = 0; i < NSH; i++) begin
                    for (int j = 0; j < NSH; j++) begin
                        n_mid_t[i][j] = WIDTH'(prod[i][j]);
                    end
                end
                n_mid_rs[0] = fw[0] + fw[1];
                n_mid_rs[1] = fw[2] - fw[0];
                n_mid_rs[2] = '0 - fw[1] - fw[2];
            end
            default: begin
                n_mid_arith = 1'b0;
            end
        endcase
    end

    // Recombine each output share from its registered terms, wrapping at WIDTH bits
    always_comb begin
        logic [WIDTH-1:0] acc;
        for (int i = 0; i < NSH; i++) begin
            if (r_mid_arith) begin
                acc = r_mid_t[i][0] + r_mid_t[i][1] + r_mid_t[i][2] + r_mid_rs[i];
            end else begin
                acc = r_mid_t[i][0] ^ r_mid_t[i][1] ^ r_mid_t[i][2];
            end
            n_out_share[i] = WORD_W'(acc);
        end
    end

    // Hold the stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // Advance the payload registers
    always_ff @(posedge i_clk) begin
        if (adv_in && i_in_valid) begin
            r_in_kind  <= dma_pkg::t_kind'(i_kind);
            r_in_count <= n_in_count;
            r_in_a     <= n_in_a;
            r_in_b     <= n_in_b;
            r_in_f     <= n_in_f;
        end
        if (adv_mid && r_in_valid) begin
            r_mid_arith <= n_mid_arith;
            r_mid_t     <= n_mid_t;
            r_mid_rs    <= n_mid_rs;
        end
        if (adv_out && r_mid_valid) begin
            r_out_share <= n_out_share;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_share0 = r_out_share[0];
    assign o_out_share1 = r_out_share[1];
    assign o_out_share2 = r_out_share[2];

endmodule

`default_nettype wire

### rtl/dma_checker.sv
// Port-level checks for the masked ALU, bound to the top level.
`default_nettype none

module dma_checker #(
    parameter int WIDTH = 32
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic [dma_pkg::KIND_W-1:0]  i_kind,
    input wire logic [dma_pkg::WORD_W-1:0]  i_a_share0,
    input wire logic [dma_pkg::WORD_W-1:0]  i_a_share1,
    input wire logic [dma_pkg::WORD_W-1:0]  i_a_share2,
    input wire logic [dma_pkg::WORD_W-1:0]  i_b_share0,
    input wire logic [dma_pkg::WORD_W-1:0]  i_b_share1,
    input wire logic [dma_pkg::WORD_W-1:0]  i_b_share2,
    input wire logic [dma_pkg::WORD_W-1:0]  i_fresh0,
    input wire logic [dma_pkg::WORD_W-1:0]  i_fresh1,
    input wire logic [dma_pkg::WORD_W-1:0]  i_fresh2,
    input wire logic [dma_pkg::AMT_W-1:0]   i_shift_amount,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [dma_pkg::WORD_W-1:0]  o_out_share0,
    input wire logic [dma_pkg::WORD_W-1:0]  o_out_share1,
    input wire logic [dma_pkg::WORD_W-1:0]  o_out_share2
);

    localparam int WORD_W = dma_pkg::WORD_W;
    localparam logic [WORD_W-1:0] MASK =
        (WIDTH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << WIDTH) - 64'd1);

    logic in_take;
    assign in_take = i_in_valid && !o_in_stall;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // Input back-pressure only comes from a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // An unobstructed XOR word emerges from the result register, share-wise (share 1 is checked)
    a_xor_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_kind == dma_pkg::KIND_XOR) ##1 !i_out_stall ##1 !i_out_stall
        |=> o_out_valid && o_out_share1 == (($past(i_a_share1, 3) ^ $past(i_b_share1, 3))
                                            & MASK))
        else $error("XOR word missing or wrong after three cycles");

    // Stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped under stall");

    // Stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_out_share0) && $stable(o_out_share1)
                                          && $stable(o_out_share2)))
        else $error("output word changed under stall");

endmodule

bind dom_masked_alu dma_checker #(.WIDTH(WIDTH)) u_dma_checker (.*);

`default_nettype wire

### dv/dom_masked_alu_tb.sv
// Self-checking testbench for the three-share masked ALU.
`timescale 1ns / 1ps

module dom_masked_alu_tb;

    localparam int                WORD_W     = dma_pkg::WORD_W;
    localparam int                KIND_W     = dma_pkg::KIND_W;
    localparam int                AMT_W      = dma_pkg::AMT_W;
    localparam int                NSH        = dma_pkg::NSH;
    localparam int                TAIL_OPS   = 150;   // final stretch driven without idling
    localparam int                RANDOM_OPS = 1750;
    localparam int                STALL_CAP  = 1000;  // cycles without any handshake
    localparam logic [WORD_W-1:0] ONES       = '1;

    typedef logic [NSH-1:0][WORD_W-1:0] t_shares;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_shares           a;
        t_shares           b;
        t_shares           fresh;
        logic [AMT_W-1:0]  amt;
    } t_alu_op;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                i_out_stall    = 1'b0;
    logic [KIND_W-1:0]   i_kind         = '0;
    logic [WORD_W-1:0]   i_a_share0     = '0;
    logic [WORD_W-1:0]   i_a_share1     = '0;
    logic [WORD_W-1:0]   i_a_share2     = '0;
    logic [WORD_W-1:0]   i_b_share0     = '0;
    logic [WORD_W-1:0]   i_b_share1     = '0;
    logic [WORD_W-1:0]   i_b_share2     = '0;
    logic [WORD_W-1:0]   i_fresh0       = '0;
    logic [WORD_W-1:0]   i_fresh1       = '0;
    logic [WORD_W-1:0]   i_fresh2       = '0;
    logic [AMT_W-1:0]    i_shift_amount = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [WORD_W-1:0]   o_out_share0;
    logic [WORD_W-1:0]   o_out_share1;
    logic [WORD_W-1:0]   o_out_share2;

    t_alu_op op_backlog[$];
    t_shares due_shares[$];
    t_alu_op op_on_bus;
    int      mismatches  = 0;
    int      in_gap      = 0;
    int      out_hold    = 0;
    int      idle_cycles = 0;

    dom_masked_alu #(
        .WIDTH (WORD_W),
        .SHARES(NSH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_a_share0    (i_a_share0),
        .i_a_share1    (i_a_share1),
        .i_a_share2    (i_a_share2),
        .i_b_share0    (i_b_share0),
        .i_b_share1    (i_b_share1),
        .i_b_share2    (i_b_share2),
        .i_fresh0      (i_fresh0),
        .i_fresh1      (i_fresh1),
        .i_fresh2      (i_fresh2),
        .i_shift_amount(i_shift_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_share0  (o_out_share0),
        .o_out_share1  (o_out_share1),
        .o_out_share2  (o_out_share2)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Compute the output shares of one operation
    function automatic t_shares masked_result(t_alu_op op);
        t_shares          o;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] r;
        int               n;
        int               k;
        bit               arith;
        o     = '0;
        n     = op.amt % WORD_W;
        arith = (op.kind == dma_pkg::KIND_MULT);
        case (op.kind)
            dma_pkg::KIND_AND, dma_pkg::KIND_OR, dma_pkg::KIND_MULT: begin
                // own-domain products, then reshare every cross product
                for (int i = 0; i < NSH; i++)
                    o[i] = arith ? op.a[i] * op.b[i] : op.a[i] & op.b[i];
                k = 0;
                for (int i = 0; i < NSH - 1; i++) begin
                    for (int j = i + 1; j < NSH; j++) begin
                        r = op.fresh[k % 3];
                        k++;
                        if (arith) begin
                            o[i] = o[i] + op.a[i] * op.b[j] + r;
                            o[j] = o[j] + op.a[j] * op.b[i] - r;
                        end else begin
                            o[i] = o[i] ^ (op.a[i] & op.b[j]) ^ r;
                            o[j] = o[j] ^ (op.a[j] & op.b[i]) ^ r;
                        end
                    end
                end
                if (op.kind == dma_pkg::KIND_OR)
                    o = o ^ op.a ^ op.b;
            end
            dma_pkg::KIND_XOR: o = op.a ^ op.b;
            dma_pkg::KIND_ADD: begin
                for (int i = 0; i < NSH; i++)
                    o[i] = op.a[i] + op.b[i];
            end
            dma_pkg::KIND_NOT: begin
                o    = op.a;
                o[0] = ~op.a[0];
            end
            dma_pkg::KIND_SHR, dma_pkg::KIND_SHL, dma_pkg::KIND_ROTR, dma_pkg::KIND_ROTL: begin
                for (int i = 0; i < NSH; i++) begin
                    v = op.a[i];
                    if (n == 0)
                        o[i] = v;
                    else if (op.kind == dma_pkg::KIND_SHR)
                        o[i] = v >> n;
                    else if (op.kind == dma_pkg::KIND_SHL)
                        o[i] = v << n;
                    else if (op.kind == dma_pkg::KIND_ROTR)
                        o[i] = (v >> n) | (v << (WORD_W - n));
                    else
                        o[i] = (v << n) | (v >> (WORD_W - n));
                end
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    // Word with a bias towards the corners: zero, all ones, one hot
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_shares pick_shares();
        t_shares s;
        for (int i = 0; i < NSH; i++)
            s[i] = pick_word();
        return s;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] kind, input t_shares a, input t_shares b,
                            input t_shares fresh, input logic [AMT_W-1:0] amt);
        t_alu_op op;
        op.kind  = kind;
        op.a     = a;
        op.b     = b;
        op.fresh = fresh;
        op.amt   = amt;
        op_backlog.push_back(op);
    endtask

    // Driver: predict on acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                due_shares.push_back(masked_result(op_on_bus));
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (op_backlog.size() >= TAIL_OPS && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 3);
                    i_in_valid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    op_on_bus = op_backlog.pop_front();
                    i_kind         <= op_on_bus.kind;
                    i_a_share0     <= op_on_bus.a[0];
                    i_a_share1     <= op_on_bus.a[1];
                    i_a_share2     <= op_on_bus.a[2];
                    i_b_share0     <= op_on_bus.b[0];
                    i_b_share1     <= op_on_bus.b[1];
                    i_b_share2     <= op_on_bus.b[2];
                    i_fresh0       <= op_on_bus.fresh[0];
                    i_fresh1       <= op_on_bus.fresh[1];
                    i_fresh2       <= op_on_bus.fresh[2];
                    i_shift_amount <= op_on_bus.amt;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output word against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        t_shares got;
        t_shares want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_out_share2, o_out_share1, o_out_share0};
                if (due_shares.size() == 0) begin
                    $error("output word with no operation outstanding: %h", got);
                    mismatches++;
                end else begin
                    want = due_shares.pop_front();
                    for (int i = 0; i < NSH; i++) begin
                        if (got[i] !== want[i]) begin
                            $error("out_share%0d: expected %h, got %h", i, want[i], got[i]);
                            mismatches++;
                        end
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else if (op_backlog.size() >= TAIL_OPS && $urandom_range(0, 5) == 0) begin
                out_hold = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: give up when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [KIND_W-1:0] kind;

        // Directed: corners of every operation
        queue_op(dma_pkg::KIND_AND, {3{ONES}}, {3{ONES}}, '0, '0);
        queue_op(dma_pkg::KIND_AND, '0, {3{ONES}}, {3{ONES}}, '0);
        queue_op(dma_pkg::KIND_OR, pick_shares(), pick_shares(), pick_shares(), '0);
        queue_op(dma_pkg::KIND_OR, {3{ONES}}, '0, {3{ONES}}, '0);
        queue_op(dma_pkg::KIND_XOR, {3{ONES}}, '0, pick_shares(), '0);
        queue_op(dma_pkg::KIND_NOT, '0, pick_shares(), pick_shares(), '0);
        queue_op(dma_pkg::KIND_NOT, {3{ONES}}, '0, '0, '1);
        queue_op(dma_pkg::KIND_SHR, pick_shares(), pick_shares(), '0, '0);
        queue_op(dma_pkg::KIND_SHL, pick_shares(), '0, '0, AMT_W'(WORD_W));
        queue_op(dma_pkg::KIND_ROTR, pick_shares(), '0, '0, AMT_W'(WORD_W - 1));
        queue_op(dma_pkg::KIND_ROTL, pick_shares(), '0, '0, '1);
        queue_op(dma_pkg::KIND_SHR, {3{ONES}}, '0, '0, AMT_W'(1));
        queue_op(dma_pkg::KIND_SHL, {3{ONES}}, '0, '0, AMT_W'(WORD_W + 1));
        queue_op(dma_pkg::KIND_ROTR, {3{32'h8000_0001}}, '0, '0, AMT_W'(1));
        queue_op(dma_pkg::KIND_ROTL, {3{32'h8000_0001}}, '0, '0, AMT_W'(WORD_W * 2));
        queue_op(dma_pkg::KIND_ADD, {3{ONES}}, {3{WORD_W'(1)}}, pick_shares(), '0);
        queue_op(dma_pkg::KIND_ADD, '0, '0, '0, '0);
        queue_op(dma_pkg::KIND_MULT, {3{ONES}}, {3{ONES}}, {3{ONES}}, '1);
        queue_op(dma_pkg::KIND_MULT, pick_shares(), pick_shares(), pick_shares(), '0);
        queue_op(dma_pkg::KIND_MULT + 4'd1, {3{ONES}}, {3{ONES}}, {3{ONES}}, '1);
        queue_op('1, pick_shares(), pick_shares(), pick_shares(), '1);

        // Random: mostly defined operations, a few unused codes
        repeat (RANDOM_OPS) begin
            if ($urandom_range(0, 15) == 0)
                kind = KIND_W'($urandom_range(int'(dma_pkg::KIND_MULT) + 1,
                                              (1 << KIND_W) - 1));
            else
                kind = KIND_W'($urandom_range(0, int'(dma_pkg::KIND_MULT)));
            queue_op(kind, pick_shares(), pick_shares(), pick_shares(),
                     AMT_W'($urandom_range(0, (1 << AMT_W) - 1)));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent, every prediction consumed, then a short tail
        while (op_backlog.size() != 0 || i_in_valid || due_shares.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatches == 0 && due_shares.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
